// ===== hdl/swerve_module_kinematics_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the swerve module kinematics block
// Immediate-implication and next-cycle-implication property checks.
// ----------------------------------------------------------------------------
`ifndef SWERVE_MODULE_KINEMATICS_ASSERT_SVH
`define SWERVE_MODULE_KINEMATICS_ASSERT_SVH

`define SMK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smk assertion failed");

`define SMK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smk assertion failed");

`endif

// ===== hdl/smk_pkg.sv =====
// ----------------------------------------------------------------------------
// Swerve module kinematics package
// Field widths, fixed-point constants, register codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smk_pkg;

   localparam int XY_W        = 30;
   localparam int STICK_W     = 11;
   localparam int ANGLE_IN_W  = 16;
   localparam int SPEED_IN_W  = 15;
   localparam int ANGLE_OUT_W = 15;
   localparam int SPEED_OUT_W = 22;
   localparam int DEG_W       = 9;
   localparam int GAIN_W      = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int NUM_WHEELS  = 4;
   localparam int WHEEL_W     = 2;
   localparam int MAX_STAGES  = 24;

   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [29:0] K_Q30       = 30'd652032874;
   localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;

   localparam logic [63:0] ATAN_Q30 [MAX_STAGES] = '{
      64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
      64'd67021687,  64'd33543516,  64'd16775851,  64'd8388437,
      64'd4194283,   64'd2097149,   64'd1048576,   64'd524288,
      64'd262144,    64'd131072,    64'd65536,     64'd32768,
      64'd16384,     64'd8192,      64'd4096,      64'd2048,
      64'd1024,      64'd512,       64'd256,       64'd128
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET0    = 3'd0,
      CSR_OFFSET1    = 3'd1,
      CSR_OFFSET2    = 3'd2,
      CSR_OFFSET3    = 3'd3,
      CSR_SPEED_GAIN = 3'd4
   } csr_index_type;

   localparam logic signed [DEG_W-1:0] OFFSET_RESET [NUM_WHEELS] = '{
      9'sd57, 9'sd78, -9'sd100, 9'sd60
   };
   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd300;

   typedef struct packed {
      logic [WHEEL_W-1:0]           wheel;
      logic                         idle;
      logic signed [ANGLE_IN_W-1:0] meas_angle;
      logic signed [SPEED_IN_W-1:0] meas_speed;
   } side_type;

   typedef struct packed {
      logic [WHEEL_W-1:0]            wheel;
      logic signed [ANGLE_OUT_W-1:0] angle_err;
      logic signed [SPEED_OUT_W-1:0] speed_err;
   } result_type;

   // Rounds a Q30 constant half-up to the given number of fraction bits.
   function automatic logic [63:0] to_q(input logic [63:0] c30, input int frac);
      return (c30 + (64'd1 << (29 - frac))) >> (30 - frac);
   endfunction

endpackage

// ===== hdl/smk_req_if.sv =====
// ----------------------------------------------------------------------------
// Swerve kinematics request channel
// Stick command and measured state of all four modules, one item per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smk_req_if;
   logic valid;
   logic ready;
   logic signed [smk_pkg::STICK_W-1:0]    stick_x;
   logic signed [smk_pkg::STICK_W-1:0]    stick_y;
   logic signed [smk_pkg::STICK_W-1:0]    stick_rot;
   logic signed [smk_pkg::ANGLE_IN_W-1:0] meas_angle_0;
   logic signed [smk_pkg::ANGLE_IN_W-1:0] meas_angle_1;
   logic signed [smk_pkg::ANGLE_IN_W-1:0] meas_angle_2;
   logic signed [smk_pkg::ANGLE_IN_W-1:0] meas_angle_3;
   logic signed [smk_pkg::SPEED_IN_W-1:0] meas_speed_0;
   logic signed [smk_pkg::SPEED_IN_W-1:0] meas_speed_1;
   logic signed [smk_pkg::SPEED_IN_W-1:0] meas_speed_2;
   logic signed [smk_pkg::SPEED_IN_W-1:0] meas_speed_3;

   modport source (output valid, stick_x, stick_y, stick_rot,
                   meas_angle_0, meas_angle_1, meas_angle_2, meas_angle_3,
                   meas_speed_0, meas_speed_1, meas_speed_2, meas_speed_3,
                   input ready);
   modport sink (input valid, stick_x, stick_y, stick_rot,
                 meas_angle_0, meas_angle_1, meas_angle_2, meas_angle_3,
                 meas_speed_0, meas_speed_1, meas_speed_2, meas_speed_3,
                 output ready);
endinterface

// ===== hdl/smk_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Swerve kinematics response channel
// Angle and speed errors of all four modules, one result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smk_rsp_if;
   logic valid;
   logic ready;
   logic signed [smk_pkg::ANGLE_OUT_W-1:0] angle_err_0;
   logic signed [smk_pkg::ANGLE_OUT_W-1:0] angle_err_1;
   logic signed [smk_pkg::ANGLE_OUT_W-1:0] angle_err_2;
   logic signed [smk_pkg::ANGLE_OUT_W-1:0] angle_err_3;
   logic signed [smk_pkg::SPEED_OUT_W-1:0] speed_err_0;
   logic signed [smk_pkg::SPEED_OUT_W-1:0] speed_err_1;
   logic signed [smk_pkg::SPEED_OUT_W-1:0] speed_err_2;
   logic signed [smk_pkg::SPEED_OUT_W-1:0] speed_err_3;

   modport source (output valid, angle_err_0, angle_err_1, angle_err_2, angle_err_3,
                   speed_err_0, speed_err_1, speed_err_2, speed_err_3,
                   input ready);
   modport sink (input valid, angle_err_0, angle_err_1, angle_err_2, angle_err_3,
                 speed_err_0, speed_err_1, speed_err_2, speed_err_3,
                 output ready);
endinterface

// ===== hdl/smk_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation toward the x axis, registered, with side data passed on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smk_cordic_cell #(
   parameter int STAGE = 0,
   parameter int FRAC  = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [smk_pkg::XY_W-1:0]   in_x,
   input  logic signed [smk_pkg::XY_W-1:0]   in_y,
   input  logic signed [FRAC+3:0]            in_acc,
   input  smk_pkg::side_type                 in_side,
   output logic                              out_valid,
   output logic signed [smk_pkg::XY_W-1:0]   out_x,
   output logic signed [smk_pkg::XY_W-1:0]   out_y,
   output logic signed [FRAC+3:0]            out_acc,
   output smk_pkg::side_type                 out_side
);
   localparam int AW = FRAC + 4;
   localparam logic signed [AW-1:0] ATAN = AW'(smk_pkg::to_q(smk_pkg::ATAN_Q30[STAGE], FRAC));

   logic                             valid_ff;
   logic signed [smk_pkg::XY_W-1:0]  x_ff, x_in;
   logic signed [smk_pkg::XY_W-1:0]  y_ff, y_in;
   logic signed [AW-1:0]             acc_ff, acc_in;
   smk_pkg::side_type                side_ff;

   always_comb begin
      if (!in_y[smk_pkg::XY_W-1]) begin
         x_in   = in_x + (in_y >>> STAGE);
         y_in   = in_y - (in_x >>> STAGE);
         acc_in = in_acc + ATAN;
      end else begin
         x_in   = in_x - (in_y >>> STAGE);
         y_in   = in_y + (in_x >>> STAGE);
         acc_in = in_acc - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         acc_ff  <= acc_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side_ff;
endmodule

// ===== hdl/smk_post.sv =====
// ----------------------------------------------------------------------------
// Swerve module post-processing pipeline
// Speed scaling, offset conversion, angle wrap, wheel reversal and speed error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smk_post #(
   parameter int FRAC = 13
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic signed [smk_pkg::XY_W-1:0]       in_x,
   input  logic signed [FRAC+3:0]                in_acc,
   input  smk_pkg::side_type                     in_side,
   input  logic signed [smk_pkg::DEG_W-1:0]      offset_deg [smk_pkg::NUM_WHEELS],
   input  logic [smk_pkg::GAIN_W-1:0]            speed_gain,
   output logic                                  out_valid,
   output smk_pkg::result_type                   out_result
);
   localparam int AW     = FRAC + 4;
   localparam int EW     = ((AW > 16) ? AW : 16) + 2;
   localparam int SH_OFF = 32 - FRAC;
   localparam int MW     = 41 - SH_OFF;
   localparam int QW     = FRAC + 3;
   localparam int SH     = EW + FRAC + 4;
   localparam int RW     = SH - FRAC;
   localparam int PW     = EW + 1 + RW;
   localparam int KW     = EW - FRAC + 1;
   localparam int LW     = 15;

   localparam logic [63:0] PI_U    = smk_pkg::to_q(smk_pkg::PI_Q30, FRAC);
   localparam logic [63:0] RINV_U  = (64'd1 << SH) / (PI_U * 64'd2);
   localparam logic [63:0] DEN_HALF_U = 64'd90 << (30 - FRAC);
   localparam logic [29:0] R45     = 30'd763549742;

   localparam logic signed [EW-1:0] PI_E     = EW'(PI_U);
   localparam logic signed [EW-1:0] TWO_PI_E = EW'(PI_U * 64'd2);
   localparam logic signed [EW-1:0] HALF_E   = EW'(smk_pkg::to_q(smk_pkg::HALF_PI_Q30, FRAC));
   localparam logic signed [AW-1:0] QUARTER  = AW'(smk_pkg::to_q(smk_pkg::ATAN_Q30[0], FRAC));
   localparam logic signed [RW-1:0] RINV_S   = RW'(RINV_U);

   localparam logic signed [25:0] SAT_MAX = 26'sd2097151;
   localparam logic signed [25:0] SAT_MIN = -26'sd2097152;

   // Stage 1: split speed products and offset numerator.
   logic                          v1_ff;
   logic [44:0]                   pl_ff, ph_ff;
   logic [40:0]                   n_ff;
   logic signed [AW-1:0]          head1_ff;
   logic                          neg1_ff;
   smk_pkg::side_type             side1_ff;
   logic [smk_pkg::XY_W-1:0]      cx_u;
   logic signed [smk_pkg::DEG_W-1:0] deg;
   logic [smk_pkg::DEG_W:0]       mag;
   logic signed [AW-1:0]          head_in;

   always_comb begin
      cx_u    = in_side.idle ? '0 : in_x[smk_pkg::XY_W-1:0];
      deg     = offset_deg[in_side.wheel];
      mag     = deg[smk_pkg::DEG_W-1] ? (smk_pkg::DEG_W+1)'(-((smk_pkg::DEG_W+1)'(deg)))
                                      : (smk_pkg::DEG_W+1)'(deg);
      head_in = in_side.idle ? (in_side.wheel[0] ? QUARTER : -QUARTER) : in_acc;
   end

   // Stage 2: speed in Q16 and offset quotient.
   logic                          v2_ff;
   logic [29:0]                   s_ff;
   logic [QW-1:0]                 q_ff;
   logic signed [AW-1:0]          head2_ff;
   logic                          neg2_ff;
   smk_pkg::side_type             side2_ff;
   logic [59:0]                   s_sum;
   logic [MW-1:0]                 m_val;
   logic [MW+29:0]                q_prod;

   always_comb begin
      s_sum  = {ph_ff, 15'b0} + 60'(pl_ff) + (60'd1 << 29);
      m_val  = n_ff[40:SH_OFF];
      q_prod = (MW+30)'(m_val) * (MW+30)'(R45);
   end

   // Stage 3: speed target and raw angle error.
   logic                          v3_ff;
   logic [23:0]                   t3_ff;
   logic signed [EW-1:0]          e3_ff;
   smk_pkg::side_type             side3_ff;
   logic [39:0]                   t_prod;
   logic signed [EW-1:0]          off_e;
   logic signed [EW-1:0]          e_raw;

   always_comb begin
      t_prod = 40'(s_ff) * 40'(speed_gain) + 40'd32768;
      off_e  = EW'(signed'({1'b0, q_ff}));
      e_raw  = EW'(head2_ff) + (neg2_ff ? -off_e : off_e) - EW'(side2_ff.meas_angle);
   end

   // Stage 4: turn count estimate.
   logic                          v4_ff;
   logic [23:0]                   t4_ff;
   logic signed [EW-1:0]          e4_ff;
   logic signed [KW-1:0]          k4_ff;
   smk_pkg::side_type             side4_ff;
   logic signed [EW:0]            e_pi;
   logic signed [PW-1:0]          k_prod;

   always_comb begin
      e_pi   = (EW+1)'(e3_ff) + (EW+1)'(PI_E);
      k_prod = PW'(e_pi) * PW'(RINV_S);
   end

   // Stage 5: coarse wrap.
   logic                          v5_ff;
   logic [23:0]                   t5_ff;
   logic signed [EW-1:0]          e5_ff;
   smk_pkg::side_type             side5_ff;

   // Stage 6: fine wrap into (-pi, pi].
   logic                          v6_ff;
   logic [23:0]                   t6_ff;
   logic signed [EW-1:0]          e6_ff;
   smk_pkg::side_type             side6_ff;
   logic signed [EW-1:0]          corr;

   always_comb begin
      corr = '0;
      if (e5_ff > PI_E) begin
         corr = -TWO_PI_E;
      end
      if (e5_ff <= -PI_E) begin
         corr = TWO_PI_E;
      end
      if (e5_ff <= -(PI_E + TWO_PI_E)) begin
         corr = TWO_PI_E + TWO_PI_E;
      end
   end

   // Stage 7: wheel reversal and saturated speed error.
   logic                          v7_ff;
   smk_pkg::result_type           res_ff;
   logic signed [EW-1:0]          e_fin;
   logic                          flip;
   logic signed [25:0]            t_s;
   logic signed [25:0]            err;
   logic signed [smk_pkg::SPEED_OUT_W-1:0] err_sat;

   always_comb begin
      e_fin = e6_ff;
      flip  = 1'b0;
      if (e6_ff > HALF_E) begin
         e_fin = e6_ff - PI_E;
         flip  = 1'b1;
      end else if (e6_ff < -HALF_E) begin
         e_fin = e6_ff + PI_E;
         flip  = 1'b1;
      end
      t_s = 26'(signed'({1'b0, t6_ff}));
      err = ((side6_ff.wheel[0] ^ flip) ? -t_s : t_s) - 26'(side6_ff.meas_speed);
      if (err > SAT_MAX) begin
         err_sat = smk_pkg::SPEED_OUT_W'(SAT_MAX);
      end else if (err < SAT_MIN) begin
         err_sat = smk_pkg::SPEED_OUT_W'(SAT_MIN);
      end else begin
         err_sat = smk_pkg::SPEED_OUT_W'(err);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      if (advance) begin
         pl_ff    <= 45'(cx_u[LW-1:0]) * 45'(smk_pkg::K_Q30);
         ph_ff    <= 45'(cx_u[smk_pkg::XY_W-1:LW]) * 45'(smk_pkg::K_Q30);
         n_ff     <= 41'(mag) * 41'(smk_pkg::PI_Q30) + 41'(DEN_HALF_U);
         head1_ff <= head_in;
         neg1_ff  <= deg[smk_pkg::DEG_W-1];
         side1_ff <= in_side;

         s_ff     <= s_sum[59:30];
         q_ff     <= q_prod[35 +: QW];
         head2_ff <= head1_ff;
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;

         t3_ff    <= t_prod[39:16];
         e3_ff    <= e_raw;
         side3_ff <= side2_ff;

         t4_ff    <= t3_ff;
         e4_ff    <= e3_ff;
         k4_ff    <= KW'(k_prod >>> SH);
         side4_ff <= side3_ff;

         t5_ff    <= t4_ff;
         e5_ff    <= e4_ff - EW'(EW'(k4_ff) * TWO_PI_E);
         side5_ff <= side4_ff;

         t6_ff    <= t5_ff;
         e6_ff    <= e5_ff + corr;
         side6_ff <= side5_ff;

         res_ff.wheel     <= side6_ff.wheel;
         res_ff.angle_err <= smk_pkg::ANGLE_OUT_W'(e_fin);
         res_ff.speed_err <= err_sat;
      end
   end

   assign out_valid  = v7_ff;
   assign out_result = res_ff;
endmodule

// ===== hdl/swerve_module_kinematics.sv =====
// ----------------------------------------------------------------------------
// Swerve module kinematics
// Four-module swerve inverse kinematics with steering and speed errors.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  req_bus   in         stick x/y/rotation, measured angle and speed of 4 modules
//  rsp_bus   out        angle error and saturated speed error of 4 modules
//  csr_*     in         write-only offsets (index 0..3) and speed gain (index 4)
//
// A request beat is taken only as the last module of the one before enters; the
// four modules share one CORDIC chain and enter it one per cycle unless stalled.
// Reset clears all valid flags and loads the default offsets and gain.
// A response beat that is not taken freezes the whole pipeline until it is.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "swerve_module_kinematics_assert.svh"

module swerve_module_kinematics #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   smk_req_if.sink                           req_bus,
   smk_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [smk_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smk_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int AW = ANGLE_FRAC_BITS + 4;
   localparam int XW = smk_pkg::XY_W;
   localparam int NW = smk_pkg::NUM_WHEELS;

   logic advance;
   logic rsp_valid_ff;

   // Configuration registers.
   logic signed [smk_pkg::DEG_W-1:0] offset_ff [NW];
   logic [smk_pkg::GAIN_W-1:0]       gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= smk_pkg::OFFSET_RESET;
         gain_ff   <= smk_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (smk_pkg::csr_index_type'(csr_index))
            smk_pkg::CSR_OFFSET0:    offset_ff[0] <= csr_wdata[smk_pkg::DEG_W-1:0];
            smk_pkg::CSR_OFFSET1:    offset_ff[1] <= csr_wdata[smk_pkg::DEG_W-1:0];
            smk_pkg::CSR_OFFSET2:    offset_ff[2] <= csr_wdata[smk_pkg::DEG_W-1:0];
            smk_pkg::CSR_OFFSET3:    offset_ff[3] <= csr_wdata[smk_pkg::DEG_W-1:0];
            smk_pkg::CSR_SPEED_GAIN: gain_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Request holding register and module sequencer.
   logic                                   busy_ff;
   logic [smk_pkg::WHEEL_W-1:0]            sel_ff;
   logic signed [smk_pkg::STICK_W-1:0]     hx_ff, hy_ff, hz_ff;
   logic signed [smk_pkg::ANGLE_IN_W-1:0]  hang_ff [NW];
   logic signed [smk_pkg::SPEED_IN_W-1:0]  hspd_ff [NW];
   logic                                   accept;
   logic                                   issue;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance && (!busy_ff || (sel_ff == smk_pkg::WHEEL_W'(NW - 1)));
   assign accept        = req_bus.valid && req_bus.ready;
   assign issue         = advance && busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sel_ff  <= '0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            sel_ff  <= '0;
         end else if (issue) begin
            sel_ff <= sel_ff + 1'b1;
            if (sel_ff == smk_pkg::WHEEL_W'(NW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
      if (accept) begin
         hx_ff      <= req_bus.stick_x;
         hy_ff      <= req_bus.stick_y;
         hz_ff      <= req_bus.stick_rot;
         hang_ff[0] <= req_bus.meas_angle_0;
         hang_ff[1] <= req_bus.meas_angle_1;
         hang_ff[2] <= req_bus.meas_angle_2;
         hang_ff[3] <= req_bus.meas_angle_3;
         hspd_ff[0] <= req_bus.meas_speed_0;
         hspd_ff[1] <= req_bus.meas_speed_1;
         hspd_ff[2] <= req_bus.meas_speed_2;
         hspd_ff[3] <= req_bus.meas_speed_3;
      end
   end

   // Velocity vector of the selected module.
   logic signed [XW-1:0] xq, yq, zr, vx_in, vy_in;
   smk_pkg::side_type    side_in;

   always_comb begin
      xq    = -(XW'(hx_ff) <<< 16);
      yq    = XW'(hy_ff) <<< 16;
      zr    = XW'(hz_ff) * XW'(signed'(smk_pkg::INV_SQRT2_Q16));
      vx_in = sel_ff[1] ? xq + zr : xq - zr;
      vy_in = (sel_ff[1] ^ sel_ff[0]) ? yq - zr : yq + zr;
      side_in.wheel      = sel_ff;
      side_in.idle       = (hx_ff == '0) && (hy_ff == '0) && (hz_ff == '0);
      side_in.meas_angle = hang_ff[sel_ff];
      side_in.meas_speed = hspd_ff[sel_ff];
   end

   logic                 ev_ff;
   logic signed [XW-1:0] ex_ff, ey_ff;
   smk_pkg::side_type    eside_ff;

   // Quadrant pre-rotation.
   logic signed [XW-1:0] px_in, py_in;
   logic signed [AW-1:0] pacc_in;
   localparam logic signed [AW-1:0] PI_A =
      AW'(smk_pkg::to_q(smk_pkg::PI_Q30, ANGLE_FRAC_BITS));

   always_comb begin
      if (ex_ff[XW-1]) begin
         px_in   = -ex_ff;
         py_in   = -ey_ff;
         pacc_in = ey_ff[XW-1] ? -PI_A : PI_A;
      end else begin
         px_in   = ex_ff;
         py_in   = ey_ff;
         pacc_in = '0;
      end
   end

   logic                 cv   [CORDIC_STAGES+1];
   logic signed [XW-1:0] cx   [CORDIC_STAGES+1];
   logic signed [XW-1:0] cy   [CORDIC_STAGES+1];
   logic signed [AW-1:0] cacc [CORDIC_STAGES+1];
   smk_pkg::side_type    cside[CORDIC_STAGES+1];

   logic                 pv_ff;
   logic signed [XW-1:0] px_ff, py_ff;
   logic signed [AW-1:0] pacc_ff;
   smk_pkg::side_type    pside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else if (advance) begin
         ev_ff <= busy_ff;
         pv_ff <= ev_ff;
      end
      if (advance) begin
         ex_ff    <= vx_in;
         ey_ff    <= vy_in;
         eside_ff <= side_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pacc_ff  <= pacc_in;
         pside_ff <= eside_ff;
      end
   end

   assign cv[0]    = pv_ff;
   assign cx[0]    = px_ff;
   assign cy[0]    = py_ff;
   assign cacc[0]  = pacc_ff;
   assign cside[0] = pside_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      smk_cordic_cell #(
         .STAGE (g),
         .FRAC  (ANGLE_FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cv[g]),
         .in_x      (cx[g]),
         .in_y      (cy[g]),
         .in_acc    (cacc[g]),
         .in_side   (cside[g]),
         .out_valid (cv[g+1]),
         .out_x     (cx[g+1]),
         .out_y     (cy[g+1]),
         .out_acc   (cacc[g+1]),
         .out_side  (cside[g+1])
      );
   end

   logic                post_valid;
   smk_pkg::result_type post_result;

   smk_post #(
      .FRAC (ANGLE_FRAC_BITS)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (cv[CORDIC_STAGES]),
      .in_x       (cx[CORDIC_STAGES]),
      .in_acc     (cacc[CORDIC_STAGES]),
      .in_side    (cside[CORDIC_STAGES]),
      .offset_deg (offset_ff),
      .speed_gain (gain_ff),
      .out_valid  (post_valid),
      .out_result (post_result)
   );

   // Result collection and response register.
   logic signed [smk_pkg::ANGLE_OUT_W-1:0] stash_ang_ff [NW-1];
   logic signed [smk_pkg::SPEED_OUT_W-1:0] stash_spd_ff [NW-1];
   logic signed [smk_pkg::ANGLE_OUT_W-1:0] rsp_ang_ff [NW];
   logic signed [smk_pkg::SPEED_OUT_W-1:0] rsp_spd_ff [NW];
   logic                                   last_beat;

   assign last_beat = advance && post_valid &&
                      (post_result.wheel == smk_pkg::WHEEL_W'(NW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && post_valid && !last_beat) begin
         stash_ang_ff[post_result.wheel[1:0]] <= post_result.angle_err;
         stash_spd_ff[post_result.wheel[1:0]] <= post_result.speed_err;
      end
      if (last_beat) begin
         for (int i = 0; i < NW - 1; i++) begin
            rsp_ang_ff[i] <= stash_ang_ff[i];
            rsp_spd_ff[i] <= stash_spd_ff[i];
         end
         rsp_ang_ff[NW-1] <= post_result.angle_err;
         rsp_spd_ff[NW-1] <= post_result.speed_err;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.angle_err_0 = rsp_ang_ff[0];
   assign rsp_bus.angle_err_1 = rsp_ang_ff[1];
   assign rsp_bus.angle_err_2 = rsp_ang_ff[2];
   assign rsp_bus.angle_err_3 = rsp_ang_ff[3];
   assign rsp_bus.speed_err_0 = rsp_spd_ff[0];
   assign rsp_bus.speed_err_1 = rsp_spd_ff[1];
   assign rsp_bus.speed_err_2 = rsp_spd_ff[2];
   assign rsp_bus.speed_err_3 = rsp_spd_ff[3];

   `SMK_ASSERT_NEXT(a_last_sets_valid, clock, reset, last_beat, rsp_valid_ff)
   `SMK_ASSERT_NEXT(a_accept_starts, clock, reset, accept, busy_ff && (sel_ff == '0))
   `SMK_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_bus.ready, !req_bus.ready && !issue)
endmodule

// ===== dv/smk_tb_if.sv =====
// ----------------------------------------------------------------------------
// Testbench channel interfaces
// The block's request and response interfaces are used as they are; this
// file only gathers the package types that the testbench shares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smk_tb_pkg;

   typedef struct {
      logic signed [smk_pkg::STICK_W-1:0]    sx;
      logic signed [smk_pkg::STICK_W-1:0]    sy;
      logic signed [smk_pkg::STICK_W-1:0]    rot;
      logic signed [smk_pkg::ANGLE_IN_W-1:0] ang [smk_pkg::NUM_WHEELS];
      logic signed [smk_pkg::SPEED_IN_W-1:0] spd [smk_pkg::NUM_WHEELS];
   } drive_cmd_type;

   typedef struct {
      logic signed [smk_pkg::ANGLE_OUT_W-1:0] aerr [smk_pkg::NUM_WHEELS];
      logic signed [smk_pkg::SPEED_OUT_W-1:0] serr [smk_pkg::NUM_WHEELS];
   } wheel_errors_type;
endpackage

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Swerve module kinematics testbench
// Drives stick commands and measured module states through random handshake
// gaps, predicts every module's angle and speed error in fixed point, and
// compares each response beat field by field under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC = 13;
   localparam int STAGES = 16;
   localparam int DRAIN = STAGES + 40;
   localparam int NW = smk_pkg::NUM_WHEELS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [smk_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [smk_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   smk_req_if req_bus ();
   smk_rsp_if rsp_bus ();

   swerve_module_kinematics #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   smk_tb_pkg::drive_cmd_type pending_cmds [$];
   smk_tb_pkg::wheel_errors_type expected_errors [$];
   longint offset_deg [NW];
   longint gain;
   int mismatches = 0;
   int beats_checked = 0;
   int idle_on = 1;
   int hold_off = 0;

   function automatic longint qconst(longint c30);
      return (c30 + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
   endfunction

   function automatic longint deg_to_rad(longint deg);
      longint mag, den, q;
      mag = (deg < 0 ? -deg : deg) * longint'(smk_pkg::PI_Q30);
      den = longint'(180) << (30 - FRAC);
      q = (mag + den / 2) / den;
      return deg < 0 ? -q : q;
   endfunction

   function automatic void heading_speed(longint cx, longint cy, output longint head,
                                         output longint spd);
      longint acc, nx, ny, a, pi;
      pi = qconst(smk_pkg::PI_Q30);
      acc = 0;
      if (cx < 0) begin
         acc = cy >= 0 ? pi : -pi;
         cx = -cx;
         cy = -cy;
      end
      for (int i = 0; i < STAGES; i++) begin
         a = qconst(smk_pkg::ATAN_Q30[i]);
         if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            acc += a;
         end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            acc -= a;
         end
         cx = nx;
         cy = ny;
      end
      head = acc;
      spd = (cx * longint'(smk_pkg::K_Q30) + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic smk_tb_pkg::wheel_errors_type predict_errors(
         smk_tb_pkg::drive_cmd_type c);
      smk_tb_pkg::wheel_errors_type r;
      longint x, y, z, zr, pi, half, quarter, head, spd, e, tgt, err, sgn, vx, vy;
      x = -longint'(c.sx);
      y = c.sy;
      z = c.rot;
      pi = qconst(smk_pkg::PI_Q30);
      half = qconst(smk_pkg::HALF_PI_Q30);
      quarter = qconst(smk_pkg::ATAN_Q30[0]);
      zr = z * longint'(smk_pkg::INV_SQRT2_Q16);
      for (int m = 0; m < NW; m++) begin
         if (x == 0 && y == 0 && z == 0) begin
            head = m[0] ? quarter : -quarter;
            spd = 0;
         end else begin
            vx = x * 65536 + (m < 2 ? -zr : zr);
            vy = y * 65536 + ((m == 0 || m == 3) ? zr : -zr);
            heading_speed(vx, vy, head, spd);
         end
         e = head + deg_to_rad(offset_deg[m]) - longint'(c.ang[m]);
         while (e > pi) e -= 2 * pi;
         while (e <= -pi) e += 2 * pi;
         sgn = m[0] ? -1 : 1;
         if (e > half) begin
            e -= pi;
            sgn = -sgn;
         end else if (e < -half) begin
            e += pi;
            sgn = -sgn;
         end
         tgt = (spd * gain + 32768) >>> 16;
         err = sgn * tgt - longint'(c.spd[m]);
         if (err > 2097151) err = 2097151;
         if (err < -2097152) err = -2097152;
         r.aerr[m] = e[smk_pkg::ANGLE_OUT_W-1:0];
         r.serr[m] = err[smk_pkg::SPEED_OUT_W-1:0];
      end
      return r;
   endfunction

   // Driver: valid stays high across back-to-back beats.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            expected_errors.push_back(predict_errors(pending_cmds.pop_front()));
         end
         if (pending_cmds.size() > 0 && (!idle_on || $urandom_range(99) >= 33)) begin
            req_bus.valid <= 1'b1;
            req_bus.stick_x <= pending_cmds[0].sx;
            req_bus.stick_y <= pending_cmds[0].sy;
            req_bus.stick_rot <= pending_cmds[0].rot;
            req_bus.meas_angle_0 <= pending_cmds[0].ang[0];
            req_bus.meas_angle_1 <= pending_cmds[0].ang[1];
            req_bus.meas_angle_2 <= pending_cmds[0].ang[2];
            req_bus.meas_angle_3 <= pending_cmds[0].ang[3];
            req_bus.meas_speed_0 <= pending_cmds[0].spd[0];
            req_bus.meas_speed_1 <= pending_cmds[0].spd[1];
            req_bus.meas_speed_2 <= pending_cmds[0].spd[2];
            req_bus.meas_speed_3 <= pending_cmds[0].spd[3];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.stick_x = '0;
      req_bus.stick_y = '0;
      req_bus.stick_rot = '0;
      req_bus.meas_angle_0 = '0;
      req_bus.meas_angle_1 = '0;
      req_bus.meas_angle_2 = '0;
      req_bus.meas_angle_3 = '0;
      req_bus.meas_speed_0 = '0;
      req_bus.meas_speed_1 = '0;
      req_bus.meas_speed_2 = '0;
      req_bus.meas_speed_3 = '0;
      rsp_bus.ready = 1'b0;
   end

   // Monitor and response-side stall control.
   always @(posedge clock) begin
      smk_tb_pkg::wheel_errors_type exp_r;
      logic signed [smk_pkg::ANGLE_OUT_W-1:0] got_a [NW];
      logic signed [smk_pkg::SPEED_OUT_W-1:0] got_s [NW];
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_a = '{rsp_bus.angle_err_0, rsp_bus.angle_err_1,
                      rsp_bus.angle_err_2, rsp_bus.angle_err_3};
            got_s = '{rsp_bus.speed_err_0, rsp_bus.speed_err_1,
                      rsp_bus.speed_err_2, rsp_bus.speed_err_3};
            if (expected_errors.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response beat at %0t", $time);
            end else begin
               exp_r = expected_errors.pop_front();
               beats_checked++;
               for (int m = 0; m < NW; m++) begin
                  if (got_a[m] !== exp_r.aerr[m] || got_s[m] !== exp_r.serr[m]) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display({"Module %0d mismatch: angle exp %0d got %0d, ",
                                  "speed exp %0d got %0d"},
                                 m, exp_r.aerr[m], got_a[m], exp_r.serr[m], got_s[m]);
                  end
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !idle_on || $urandom_range(99) >= 33;
         end
      end
   end

   function automatic smk_tb_pkg::drive_cmd_type random_cmd();
      smk_tb_pkg::drive_cmd_type c;
      int k;
      k = $urandom_range(9);
      c.sx = smk_pkg::STICK_W'($urandom);
      c.sy = smk_pkg::STICK_W'($urandom);
      c.rot = smk_pkg::STICK_W'($urandom);
      if (k == 0) begin
         c.sx = '0; c.sy = '0; c.rot = '0;
      end else if (k == 1) begin
         c.rot = '0;
      end else if (k == 2) begin
         c.sx = '0; c.sy = '0;
      end
      for (int m = 0; m < NW; m++) begin
         c.ang[m] = ($urandom_range(7) == 0) ? 16'($urandom)
                                             : 16'($signed($urandom_range(51472)) - 25736);
         c.spd[m] = smk_pkg::SPEED_IN_W'($urandom);
      end
      return c;
   endfunction

   task automatic csr_write(smk_pkg::csr_index_type idx,
                            logic [smk_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == smk_pkg::CSR_SPEED_GAIN) gain = val;
      else if (idx <= smk_pkg::CSR_OFFSET3)
         offset_deg[idx] = longint'($signed(val[smk_pkg::DEG_W-1:0]));
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() > 0 || req_bus.valid || expected_errors.size() > 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic load_setting(int s);
      case (s)
         0: begin
            csr_write(smk_pkg::CSR_OFFSET0, 10'h100);  // -256 full negative
            csr_write(smk_pkg::CSR_OFFSET1, 10'h0FF);
            csr_write(smk_pkg::CSR_OFFSET2, -10'sd180);
            csr_write(smk_pkg::CSR_OFFSET3, 10'd180);
            csr_write(smk_pkg::CSR_SPEED_GAIN, 10'd1023);
         end
         1: begin
            csr_write(smk_pkg::CSR_OFFSET0, 10'd0);
            csr_write(smk_pkg::CSR_OFFSET1, 10'd0);
            csr_write(smk_pkg::CSR_OFFSET2, 10'd0);
            csr_write(smk_pkg::CSR_OFFSET3, 10'd0);
            csr_write(smk_pkg::CSR_SPEED_GAIN, 10'd0);
         end
         2: begin
            csr_write(smk_pkg::CSR_OFFSET0, 10'($urandom));
            csr_write(smk_pkg::CSR_OFFSET1, 10'($urandom));
            csr_write(smk_pkg::CSR_OFFSET2, 10'($urandom));
            csr_write(smk_pkg::CSR_OFFSET3, 10'($urandom));
            csr_write(smk_pkg::CSR_SPEED_GAIN, 10'($urandom));
            csr_write(smk_pkg::csr_index_type'(3'd6), 10'($urandom));
         end
         default: begin
         end
      endcase
   endtask

   initial begin
      smk_tb_pkg::drive_cmd_type c;
      for (int m = 0; m < NW; m++) offset_deg[m] = smk_pkg::OFFSET_RESET[m];
      gain = smk_pkg::GAIN_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: stick extremes, all-zero sticks, wrap and reversal angles.
      for (int i = 0; i < 20; i++) begin
         c = random_cmd();
         case (i % 5)
            0: begin c.sx = 0; c.sy = 0; c.rot = 0; end
            1: begin c.sx = -1024; c.sy = -1024; c.rot = -1024; end
            2: begin c.sx = 1023; c.sy = 1023; c.rot = 1023; end
            3: begin c.sx = -1024; c.sy = 1023; c.rot = 0; end
            default: begin c.sx = 1023; c.sy = 0; c.rot = -1024; end
         endcase
         for (int m = 0; m < NW; m++) begin
            c.ang[m] = (i < 10) ? ((i & 1) ? 16'sd25736 : -16'sd25736)
                                : ((i & 1) ? 16'sh7FFF : 16'sh8000);
            c.spd[m] = (i & 2) ? 15'sh3FFF : 15'sh4000;
         end
         pending_cmds.push_back(c);
      end
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase > 0) load_setting(phase - 1);
         idle_on = (phase != 1);
         for (int i = 0; i < 325; i++) pending_cmds.push_back(random_cmd());
         if (phase == 2) hold_off = 300;
         wait_idle();
      end

      $display("Checked %0d response beats over four register settings, %0d mismatches.",
               beats_checked, mismatches);
      if (mismatches == 0 && expected_errors.size() == 0) begin
         $display("swerve_module_kinematics test passed");
      end else begin
         $display("swerve_module_kinematics test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("swerve_module_kinematics test failed");
      $finish;
   end
endmodule

// ===== swerve_module_kinematics.f =====
+incdir+hdl
hdl/smk_pkg.sv
hdl/smk_req_if.sv
hdl/smk_rsp_if.sv
hdl/smk_cordic_cell.sv
hdl/smk_post.sv
hdl/swerve_module_kinematics.sv
dv/smk_tb_if.sv
dv/testbench.sv
